>>> hdl/pls_pkg.sv
`default_nettype none

package pls_pkg;

  localparam int OP_W    = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;
  localparam int SLOT_W  = 6;

  localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_AT   = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  // Command from the control logic to the cell row.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> hdl/pls_cells.sv
`default_nettype none

module pls_cells #(
  parameter int CAPACITY = 32
) (
  input  wire                        clk,
  input  wire                        en,
  input  wire pls_pkg::cell_cmd_t    cmd,
  output logic [pls_pkg::VAL_W-1:0]  rd_data
);
  import pls_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [VAL_W-1:0] cells      [CAPACITY];
  logic [VAL_W-1:0] cells_next [CAPACITY];
  logic [IDX_W-1:0] idx;

  assign idx     = cmd.slot[IDX_W-1:0];
  assign rd_data = cells[idx];

  // Every cell picks its new value from itself, a neighbor or the inserted
  // value, so inserts and deletes anywhere in the row shift it in parallel.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cells_next[k] = cells[k];
      if (cmd.ins) begin
        if (IDX_W'(k) == idx) begin
          cells_next[k] = cmd.value;
        end else if (k > 0 && IDX_W'(k) > idx) begin
          cells_next[k] = cells[(k > 0) ? k - 1 : 0];
        end
      end else if (cmd.del) begin
        if (k < CAPACITY - 1 && IDX_W'(k) >= idx) begin
          cells_next[k] = cells[(k < CAPACITY - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < CAPACITY; k++) begin
        cells[k] <= cells_next[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/pls_ctrl.sv
`default_nettype none

module pls_ctrl #(
  parameter int CAPACITY = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         en,
  input  wire [pls_pkg::OP_W-1:0]     opcode,
  input  wire [pls_pkg::VAL_W-1:0]    value,
  input  wire [pls_pkg::POS_W-1:0]    position,
  input  wire [pls_pkg::VAL_W-1:0]    rd_data,
  output pls_pkg::cell_cmd_t          cmd,
  output logic [pls_pkg::STAT_W-1:0]  status,
  output logic [pls_pkg::COUNT_W-1:0] count_out,
  output logic [pls_pkg::VAL_W-1:0]   entry_value
);
  import pls_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] slot_w;
  logic             full;
  logic             empty;
  logic             take;

  assign cnt_w = CMP_W'(count);
  assign pos_w = CMP_W'(position);
  assign full  = (cnt_w == CMP_W'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    status = ST_OK;
    take   = 1'b0;
    slot_w = '0;
    cmd.ins = 1'b0;
    cmd.del = 1'b0;
    cmd.value = value;
    case (opcode)
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        if (opcode == OP_INS_LAST) begin
          slot_w = cnt_w;
        end else if (opcode == OP_INS_AT) begin
          slot_w = pos_w - CMP_W'(1);
        end
        if (full) begin
          status = ST_FULL;
        end else if (opcode == OP_INS_AT &&
                     (pos_w == '0 || pos_w > cnt_w + CMP_W'(1))) begin
          status = ST_BADPOS;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT, OP_READ_AT: begin
        if (opcode == OP_DEL_LAST) begin
          slot_w = cnt_w - CMP_W'(1);
        end else if (opcode == OP_DEL_AT || opcode == OP_READ_AT) begin
          slot_w = pos_w - CMP_W'(1);
        end
        if (empty) begin
          status = ST_EMPTY;
        end else if ((opcode == OP_DEL_AT || opcode == OP_READ_AT) &&
                     (pos_w == '0 || pos_w > cnt_w)) begin
          status = ST_BADPOS;
        end else begin
          take    = 1'b1;
          cmd.del = (opcode != OP_READ_AT);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    cmd.slot = slot_w[SLOT_W-1:0];
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.del) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (en) begin
      count <= count_next;
    end
  end

  assign count_out   = COUNT_W'(count_next);
  assign entry_value = take ? rd_data : '0;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(CAPACITY))
    else $error("count above capacity");
  a_ins_del_excl: assert property (@(posedge clk) disable iff (rst)
    !(en && cmd.ins && cmd.del))
    else $error("insert and delete at once");
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    en && cmd.ins |=> count == CNT_W'($past(count) + CNT_W'(1)))
    else $error("insert did not raise count");
  a_del_count: assert property (@(posedge clk) disable iff (rst)
    en && cmd.del |=> count == CNT_W'($past(count) - CNT_W'(1)))
    else $error("delete did not lower count");
`endif

endmodule

`default_nettype wire

>>> hdl/positional_list_store.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values, kept front first in
// a row of registers. Each request inserts (front, back or 1-based
// position), deletes (front, back or position) or reads at a position, and
// returns one response with status, the count after the request and the
// removed or read value. A request is registered on entry and its response
// is registered on exit; the whole row shifts in parallel in between, so
// a request can be accepted every cycle while the receiver keeps up, its
// response follows through the output register, and back-to-back requests
// always see the effect of the one before. A response held back by the
// receiver stalls the input register and with it the input.
// s_tdata:  [2:0] opcode, [34:3] value, [40:35] position, [47:41] zero.
// m_tdata:  [1:0] status, [7:2] count, [39:8] entry_value.
module positional_list_store #(
  parameter int CAPACITY = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,   // opcode, value, position (low bit up)
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata    // status, count, entry_value (low bit up)
);
  import pls_pkg::*;

  logic              req_valid;
  logic [OP_W-1:0]   req_op;
  logic [VAL_W-1:0]  req_value;
  logic [POS_W-1:0]  req_pos;
  logic              advance;
  cell_cmd_t         cmd;
  logic [VAL_W-1:0]  rd_data;
  logic [STAT_W-1:0] status;
  logic [COUNT_W-1:0] count;
  logic [VAL_W-1:0]  entry_value;

  assign advance  = req_valid && (!m_tvalid || m_tready);
  assign s_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req_op    <= s_tdata[2:0];
      req_value <= s_tdata[34:3];
      req_pos   <= s_tdata[40:35];
    end
  end

  pls_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .opcode      (req_op),
    .value       (req_value),
    .position    (req_pos),
    .rd_data     (rd_data),
    .cmd         (cmd),
    .status      (status),
    .count_out   (count),
    .entry_value (entry_value)
  );

  pls_cells #(.CAPACITY(CAPACITY)) u_cells (
    .clk     (clk),
    .en      (advance),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {entry_value, count, status};
    end
  end

endmodule

`default_nettype wire

>>> bench/pls_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the list store. Every accepted request is
// run through a local copy of the list, and the response it should produce
// is queued; every accepted response is compared with the oldest entry.
module pls_checker #(
  parameter int CAPACITY = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [47:0] s_tdata,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [39:0] m_tdata,
  output int          errors,
  output int          waiting,
  output int          stored
);
  import pls_pkg::*;

  // Same layout as m_tdata: status in the low bits, entry_value on top.
  typedef struct packed {
    logic [VAL_W-1:0]   entry_value;
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status;
  } answer_t;

  logic [VAL_W-1:0] row [CAPACITY];
  int               len = 0;
  int               faults = 0;
  answer_t          answers [$];

  function automatic answer_t apply_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                                            logic [POS_W-1:0] pos);
    answer_t a;
    int      slot;
    int      k;
    a = '0;
    // Position zero names no entry, so it maps past any possible slot.
    slot = (pos == 0) ? CAPACITY + 1 : int'(pos) - 1;
    case (op)
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        if (op == OP_INS_FIRST) slot = 0;
        else if (op == OP_INS_LAST) slot = len;
        if (len >= CAPACITY) begin
          a.status = ST_FULL;
        end else if (slot > len) begin
          a.status = ST_BADPOS;
        end else begin
          for (k = len; k > slot; k--) row[k] = row[k-1];
          row[slot] = val;
          len++;
        end
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT, OP_READ_AT: begin
        if (op == OP_DEL_FIRST) slot = 0;
        else if (op == OP_DEL_LAST) slot = (len == 0) ? 0 : len - 1;
        if (len == 0) begin
          a.status = ST_EMPTY;
        end else if (slot >= len) begin
          a.status = ST_BADPOS;
        end else begin
          a.entry_value = row[slot];
          if (op != OP_READ_AT) begin
            for (k = slot; k + 1 < len; k++) row[k] = row[k+1];
            len--;
          end
        end
      end
      default: ;
    endcase
    a.count = len[COUNT_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (rst) begin
      len = 0;
      answers.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (answers.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("pls_checker: unexpected response: status %0d count %0d value %0d",
                     got.status, got.count, $signed(got.entry_value));
        end else begin
          want = answers.pop_front();
          if (got.status !== want.status || got.count !== want.count ||
              got.entry_value !== want.entry_value) begin
            faults++;
            // Each pair is printed as expected/actual.
            if (faults <= 10)
              $display("pls_checker: mismatch status %0d/%0d count %0d/%0d value %0d/%0d",
                       want.status, got.status, want.count, got.count,
                       $signed(want.entry_value), $signed(got.entry_value));
          end
        end
      end
      if (s_tvalid && s_tready)
        answers.push_back(apply_request(s_tdata[2:0], s_tdata[34:3], s_tdata[40:35]));
    end
    errors  <= faults;
    waiting <= answers.size();
    stored  <= len;
  end

endmodule

>>> bench/tb_positional_list_store.sv
`timescale 1ns / 1ps

module tb_positional_list_store;
  import pls_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 1675;
  localparam int TAIL_ITEMS   = 150;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_LIMIT  = 2000;

  // Opcode 7 has no operation behind it; the block must answer it unchanged.
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [47:0] s_tdata = '0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [39:0] m_tdata;

  int errors;
  int waiting;
  int stored;

  int   src_odds = 0;
  int   sink_odds = 0;
  logic sink_hold = 1'b0;

  always #6 clk = ~clk;

  positional_list_store #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pls_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .waiting  (waiting),
    .stored   (stored)
  );

  // Offers one request and returns at the edge where it is taken. Ready is
  // looked at on the falling edge, where it is stable until the next rise.
  task automatic offer_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    logic took;
    if (src_odds != 0 && $urandom_range(0, 99) < src_odds) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, pos, val, op};
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
  endtask

  function automatic logic [OP_W-1:0] pick_opcode(mix_t mix);
    int   r;
    logic ins;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_SPARE;
    if (r < 14) return OP_READ_AT;
    ins = $urandom_range(0, 99) < ((mix == MIX_GROW) ? 75 : (mix == MIX_SHRINK) ? 25 : 50);
    case ($urandom_range(0, 2))
      0: return ins ? OP_INS_FIRST : OP_DEL_FIRST;
      1: return ins ? OP_INS_LAST : OP_DEL_LAST;
      default: return ins ? OP_INS_AT : OP_DEL_AT;
    endcase
  endfunction

  // Mostly positions near the current length, so that positional requests
  // land inside the list; the rest cover zero and the whole field.
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return POS_W'($urandom_range(1, stored + 1));
    if (r < 8) return '0;
    return POS_W'($urandom_range(0, 63));
  endfunction

  initial begin : sink
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end else if (sink_odds != 0 && $urandom_range(0, 99) < sink_odds) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int   sent;
    int   phase;
    int   span;
    int   n;
    mix_t mix;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list, out-of-range inserts, extremes of value, both ends of the
    // valid position range, the spare opcode, then back down to empty.
    offer_request(OP_READ_AT,   32'h0000_0000, 6'd1);
    offer_request(OP_DEL_FIRST, 32'h0000_0000, 6'd0);
    offer_request(OP_DEL_LAST,  32'hFFFF_FFFF, 6'd63);
    offer_request(OP_DEL_AT,    32'h0000_0000, 6'd0);
    offer_request(OP_INS_AT,    32'h1234_5678, 6'd2);
    offer_request(OP_INS_AT,    32'h1234_5678, 6'd0);
    offer_request(OP_INS_AT,    32'h8000_0000, 6'd1);
    offer_request(OP_INS_FIRST, 32'h7FFF_FFFF, 6'd63);
    offer_request(OP_INS_LAST,  32'hFFFF_FFFF, 6'd0);
    offer_request(OP_INS_AT,    32'h0000_0000, 6'd4);
    offer_request(OP_INS_AT,    32'h5555_5555, 6'd2);
    offer_request(OP_INS_AT,    32'hAAAA_AAAA, 6'd63);
    offer_request(OP_READ_AT,   32'h0000_0000, 6'd0);
    offer_request(OP_READ_AT,   32'h0000_0000, 6'd5);
    offer_request(OP_READ_AT,   32'h0000_0000, 6'd6);
    offer_request(OP_READ_AT,   32'hFFFF_FFFF, 6'd63);
    offer_request(OP_SPARE,     32'hFFFF_FFFF, 6'd63);
    offer_request(OP_DEL_AT,    32'h0000_0000, 6'd3);
    offer_request(OP_DEL_AT,    32'h0000_0000, 6'd5);
    offer_request(OP_DEL_LAST,  32'h0000_0000, 6'd0);
    offer_request(OP_DEL_FIRST, 32'h0000_0000, 6'd0);
    offer_request(OP_DEL_AT,    32'h0000_0000, 6'd1);
    offer_request(OP_READ_AT,   32'h0000_0000, 6'd1);
    offer_request(OP_DEL_LAST,  32'h0000_0000, 6'd1);
    offer_request(OP_DEL_FIRST, 32'h0000_0000, 6'd1);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      span = $urandom_range(30, 120);
      mix  = mix_t'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        src_odds  = 0;
        sink_odds = 0;
      end else begin
        src_odds  = $urandom_range(10, 50);
        sink_odds = $urandom_range(10, 50);
      end
      // A long receiver stall while requests keep coming fills the pipeline.
      if (phase == 3) begin
        src_odds  = 0;
        sink_hold = 1'b1;
      end
      if (phase == 7) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
      end
      for (n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
        if (RANDOM_ITEMS - sent <= TAIL_ITEMS) begin
          src_odds  = 0;
          sink_odds = 0;
        end
        offer_request(pick_opcode(mix), $urandom, pick_position());
        sent++;
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (waiting != 0 && n < DRAIN_LIMIT);
    repeat (8) @(posedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("tb_positional_list_store OK");
    end else begin
      $display("tb_positional_list_store NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_positional_list_store NOT OK");
    $finish;
  end

endmodule
